/* rtl/tdfe_pkg.sv */
package tdfe_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam logic [15:0] STEP_LIMIT = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_STEP    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_MOVED    = 2'd0,
    ST_NO_MATCH = 2'd1,
    ST_HALTED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_RESP
  } bk_state_t;

  typedef struct packed {
    act_t       action;
    logic [7:0] entry_from_state;
    logic [7:0] entry_symbol;
    logic [7:0] entry_next_state;
    logic [7:0] step_symbol;
  } cmd_t;

  typedef struct packed {
    logic [7:0] from_state;
    logic [7:0] symbol;
    logic [7:0] next_state;
  } entry_t;

endpackage

/* rtl/tdfe_if.sv */
interface tdfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] entry_from_state;
  logic [7:0] entry_symbol;
  logic [7:0] entry_next_state;
  logic [7:0] step_symbol;

  modport source (
    output valid, action, entry_from_state, entry_symbol, entry_next_state, step_symbol,
    input  ready
  );
  modport sink (
    input  valid, action, entry_from_state, entry_symbol, entry_next_state, step_symbol,
    output ready
  );
endinterface

interface tdfe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  from_state;
  logic [7:0]  to_state;
  logic [15:0] step_index;

  modport source (
    output valid, status, from_state, to_state, step_index,
    input  ready
  );
  modport sink (
    input  valid, status, from_state, to_state, step_index,
    output ready
  );
endinterface

/* rtl/table_driven_fsm_engine_top.sv */
// Append, restart and clear items retire as they leave the input queue.
// A step scans the table one entry per cycle, from the first entry, and stops at the first
// match, else after the last entry; it skips the scan when halted or when the table is empty.
// A step holds off the next item until its result enters the result register; other items one per cycle.
// Synchronous active-low reset empties the table, clears state, step count and halt flag,
// and drains the input queue and the result register. The table memory itself is not cleared.
module table_driven_fsm_engine_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  tdfe_in_if.sink     in_if,
  tdfe_out_if.source  out_if
);

  logic            cmd_vld;
  logic            cmd_pop;
  tdfe_pkg::cmd_t  cmd;

  tdfe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  tdfe_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop),
    .out_if  (out_if)
  );

endmodule

/* rtl/tdfe_front.sv */
module tdfe_front (
  input  logic              clk,
  input  logic              rst_n,
  tdfe_in_if.sink           in_if,
  output logic              cmd_vld,
  output tdfe_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  tdfe_pkg::cmd_t                q_mem [tdfe_pkg::QDEPTH];
  logic [tdfe_pkg::QAW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [tdfe_pkg::QAW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [tdfe_pkg::QAW:0]        cnt_r, cnt_nxt;
  logic                          push;
  logic                          pop;
  tdfe_pkg::cmd_t                in_cmd;

  localparam logic [tdfe_pkg::QAW:0] QFULL = (tdfe_pkg::QAW + 1)'(tdfe_pkg::QDEPTH);
  localparam logic [tdfe_pkg::QAW-1:0] QLAST = tdfe_pkg::QAW'(tdfe_pkg::QDEPTH - 1);

  always_comb begin
    in_cmd.action           = tdfe_pkg::act_t'(in_if.action);
    in_cmd.entry_from_state = in_if.entry_from_state;
    in_cmd.entry_symbol     = in_if.entry_symbol;
    in_cmd.entry_next_state = in_if.entry_next_state;
    in_cmd.step_symbol      = in_if.step_symbol;
  end

  assign in_if.ready = (cnt_r != QFULL);
  assign push        = in_if.valid && in_if.ready;
  assign cmd_vld     = (cnt_r != '0);
  assign pop         = cmd_pop && cmd_vld;
  assign cmd         = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QLAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QLAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

/* rtl/tdfe_back.sv */
module tdfe_back #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_vld,
  input  tdfe_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  tdfe_out_if.source      out_if
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  tdfe_pkg::entry_t     mem [MAX_ENTRIES];
  tdfe_pkg::entry_t     rd_q_r;
  tdfe_pkg::entry_t     wr_entry;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;

  tdfe_pkg::bk_state_t  state_r, state_nxt;
  logic [CW-1:0]        count_r;
  logic [7:0]           cur_r;
  logic [15:0]          steps_r;
  logic                 halted_r;
  logic                 out_vld_r;
  logic [AW-1:0]        cmp_idx_r;
  logic [7:0]           sym_r;

  tdfe_pkg::status_t    res_status_r;
  logic [7:0]           res_from_r;
  logic [7:0]           res_to_r;
  logic [15:0]          res_idx_r;

  tdfe_pkg::status_t    o_status_r;
  logic [7:0]           o_from_r;
  logic [7:0]           o_to_r;
  logic [15:0]          o_idx_r;

  logic                 hit;
  logic                 last;
  logic                 res_load;
  logic                 take_cmd;
  logic                 is_step;
  logic                 step_fast;
  logic [15:0]          steps_inc;

  assign hit       = (rd_q_r.from_state == cur_r) && (rd_q_r.symbol == sym_r);
  assign last      = ({{(CW - AW){1'b0}}, cmp_idx_r} == (count_r - 1'b1));
  assign is_step   = (cmd.action == tdfe_pkg::ACT_STEP);
  assign step_fast = halted_r || (count_r == '0);
  assign steps_inc = (steps_r == tdfe_pkg::STEP_LIMIT) ? steps_r : steps_r + 1'b1;
  assign take_cmd  = cmd_pop && cmd_vld;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdfe_pkg::BK_IDLE: begin
        if (cmd_vld && is_step) begin
          state_nxt = step_fast ? tdfe_pkg::BK_RESP : tdfe_pkg::BK_SEARCH;
        end
      end
      tdfe_pkg::BK_SEARCH: begin
        if (hit || last) begin
          state_nxt = tdfe_pkg::BK_RESP;
        end
      end
      tdfe_pkg::BK_RESP: begin
        if (!out_vld_r || out_if.ready) begin
          state_nxt = tdfe_pkg::BK_IDLE;
        end
      end
      default: state_nxt = tdfe_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    rd_addr  = '0;
    res_load = 1'b0;
    case (state_r)
      tdfe_pkg::BK_IDLE:   cmd_pop  = 1'b1;
      tdfe_pkg::BK_SEARCH: rd_addr  = AW'(cmp_idx_r + 1'b1);
      tdfe_pkg::BK_RESP:   res_load = !out_vld_r || out_if.ready;
      default: begin
        cmd_pop  = 1'b0;
        rd_addr  = '0;
        res_load = 1'b0;
      end
    endcase
  end

  assign mem_we   = take_cmd && (cmd.action == tdfe_pkg::ACT_APPEND) && (count_r < CNT_MAX);
  assign wr_entry = '{from_state: cmd.entry_from_state,
                      symbol:     cmd.entry_symbol,
                      next_state: cmd.entry_next_state};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[AW-1:0]] <= wr_entry;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tdfe_pkg::BK_IDLE;
      count_r   <= '0;
      cur_r     <= '0;
      steps_r   <= '0;
      halted_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      if (take_cmd) begin
        case (cmd.action)
          tdfe_pkg::ACT_CLEAR: begin
            count_r  <= '0;
            cur_r    <= '0;
            steps_r  <= '0;
            halted_r <= 1'b0;
          end
          tdfe_pkg::ACT_APPEND: begin
            if (count_r < CNT_MAX) begin
              count_r <= count_r + 1'b1;
            end
          end
          tdfe_pkg::ACT_RESTART: begin
            cur_r    <= '0;
            steps_r  <= '0;
            halted_r <= 1'b0;
          end
          tdfe_pkg::ACT_STEP: begin
            if (!halted_r && (count_r == '0)) begin
              halted_r <= 1'b1;
              steps_r  <= steps_inc;
            end
          end
          default: ;
        endcase
      end
      if (state_r == tdfe_pkg::BK_SEARCH) begin
        if (hit) begin
          cur_r   <= rd_q_r.next_state;
          steps_r <= steps_inc;
        end else if (last) begin
          halted_r <= 1'b1;
          steps_r  <= steps_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd && is_step) begin
      sym_r        <= cmd.step_symbol;
      cmp_idx_r    <= '0;
      res_from_r   <= cur_r;
      res_to_r     <= cur_r;
      res_idx_r    <= steps_r;
      res_status_r <= halted_r ? tdfe_pkg::ST_HALTED : tdfe_pkg::ST_NO_MATCH;
    end
    if (state_r == tdfe_pkg::BK_SEARCH) begin
      cmp_idx_r <= AW'(cmp_idx_r + 1'b1);
      if (hit) begin
        res_status_r <= tdfe_pkg::ST_MOVED;
        res_to_r     <= rd_q_r.next_state;
      end
    end
    if (res_load) begin
      o_status_r <= res_status_r;
      o_from_r   <= res_from_r;
      o_to_r     <= res_to_r;
      o_idx_r    <= res_idx_r;
    end
  end

  assign out_if.valid      = out_vld_r;
  assign out_if.status     = o_status_r;
  assign out_if.from_state = o_from_r;
  assign out_if.to_state   = o_to_r;
  assign out_if.step_index = o_idx_r;

endmodule

/* tb/tdfe_checker.sv */
module tdfe_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic clk,
  input  logic rst_n,
  tdfe_in_if   in_ch,
  tdfe_out_if  out_ch,
  output int   fail_count,
  output int   pending
);
  import tdfe_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [7:0]  from_state;
    logic [7:0]  to_state;
    logic [15:0] step_index;
  } move_t;

  entry_t      rules [MAX_ENTRIES];
  int          rule_count = 0;
  logic [7:0]  cur_state = '0;
  logic [15:0] step_count = '0;
  bit          halted = 1'b0;
  move_t       moves_q [$];
  int          errors = 0;
  int          waiting = 0;

  assign fail_count = errors;
  assign pending    = waiting;

  function automatic void rewind();
    cur_state  = '0;
    step_count = '0;
    halted     = 1'b0;
  endfunction

  function automatic move_t next_move(logic [7:0] sym);
    move_t m;
    bit    hit;
    int    k;
    m.from_state = cur_state;
    m.step_index = step_count;
    m.status     = ST_HALTED;
    m.to_state   = cur_state;
    if (!halted) begin
      hit = 1'b0;
      for (k = 0; k < rule_count; k++) begin
        if (!hit && rules[k].from_state == cur_state && rules[k].symbol == sym) begin
          cur_state = rules[k].next_state;
          hit       = 1'b1;
        end
      end
      if (step_count != STEP_LIMIT) begin
        step_count++;
      end
      m.status   = hit ? ST_MOVED : ST_NO_MATCH;
      halted     = !hit;
      m.to_state = cur_state;
    end
    return m;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    move_t want;
    if (!rst_n) begin
      rule_count = 0;
      rewind();
      moves_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        case (act_t'(in_ch.action))
          ACT_CLEAR: begin
            rule_count = 0;
            rewind();
          end
          ACT_APPEND: begin
            if (rule_count < MAX_ENTRIES) begin
              rules[rule_count] = {in_ch.entry_from_state, in_ch.entry_symbol,
                                   in_ch.entry_next_state};
              rule_count++;
            end
          end
          ACT_RESTART: rewind();
          ACT_STEP: moves_q.push_back(next_move(in_ch.step_symbol));
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (moves_q.size() == 0) begin
          $error("result with no step waiting: status %0d from_state %0d to_state %0d",
                 out_ch.status, out_ch.from_state, out_ch.to_state);
          errors++;
        end else begin
          want = moves_q.pop_front();
          check_field("status", 16'(want.status), 16'(out_ch.status));
          check_field("from_state", 16'(want.from_state), 16'(out_ch.from_state));
          check_field("to_state", 16'(want.to_state), 16'(out_ch.to_state));
          check_field("step_index", want.step_index, out_ch.step_index);
        end
      end
    end
    waiting = moves_q.size();
  end

endmodule

/* tb/tb_table_driven_fsm_engine_top.sv */
module tb_table_driven_fsm_engine_top;
  import tdfe_pkg::*;

  localparam int MAX_ENTRIES  = 64;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int HOLD_CYCLES  = 300;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   cycles = 0;
  bit   tx_fast = 1'b0;
  bit   rx_fast = 1'b0;
  bit   rx_hold = 1'b0;

  tdfe_in_if  in_ch ();
  tdfe_out_if out_ch ();

  table_driven_fsm_engine_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  tdfe_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("table_driven_fsm_engine_top test failed");
      $finish;
    end
  end

  function automatic logic [7:0] rb();
    return 8'($urandom);
  endfunction

  task automatic send(input act_t act, input logic [7:0] from_s, sym_s, next_s, step_s);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.action           <= act;
    in_ch.entry_from_state <= from_s;
    in_ch.entry_symbol     <= sym_s;
    in_ch.entry_next_state <= next_s;
    in_ch.step_symbol      <= step_s;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic add_rule(input logic [7:0] from_s, sym_s, next_s);
    send(ACT_APPEND, from_s, sym_s, next_s, rb());
  endtask

  task automatic feed(input logic [7:0] sym);
    send(ACT_STEP, rb(), rb(), rb(), sym);
  endtask

  task automatic ctl(input act_t act);
    send(act, rb(), rb(), rb(), rb());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  initial begin : sink_side
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = rx_fast ? 0 : $urandom_range(0, 17);
      if (rx_hold) begin
        rx_hold = 1'b0;
        stall   = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : source_side
    logic [7:0] states [6];
    logic [7:0] syms [4];
    int         n_states;
    int         n_syms;
    int         n_rules;
    int         n_steps;
    int         pick;
    int         base;
    int         prog;
    int         k;

    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.action           <= ACT_CLEAR;
    in_ch.entry_from_state <= '0;
    in_ch.entry_symbol     <= '0;
    in_ch.entry_next_state <= '0;
    in_ch.step_symbol      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then halted
    feed(8'h00);
    feed(8'hFF);
    ctl(ACT_RESTART);
    add_rule(8'h00, 8'h00, 8'hFF);
    add_rule(8'hFF, 8'hFF, 8'h00);
    add_rule(8'h00, 8'h00, 8'h55);
    add_rule(8'hFF, 8'hA5, 8'hAA);
    feed(8'h00);
    feed(8'hFF);
    feed(8'h00);
    feed(8'hA5);
    feed(8'h5A);
    feed(8'h00);
    ctl(ACT_RESTART);
    feed(8'h00);
    ctl(ACT_CLEAR);
    feed(8'h00);
    ctl(ACT_RESTART);
    feed(8'hFF);

    base = items_sent;
    prog = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      tx_fast = ($urandom_range(0, 4) == 0);
      rx_fast = ($urandom_range(0, 4) == 0);
      if (prog == 2 || prog == 11) begin
        tx_fast = 1'b1;
        rx_hold = 1'b1;
      end
      n_states  = $urandom_range(1, 6);
      states[0] = 8'h00;
      for (k = 1; k < 6; k++) begin
        states[k] = rb();
      end
      n_syms = $urandom_range(1, 4);
      for (k = 0; k < 4; k++) begin
        syms[k] = rb();
      end
      n_rules = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      if ($urandom_range(0, 4) == 0) begin
        ctl(ACT_RESTART);
      end else begin
        ctl(ACT_CLEAR);
      end
      for (k = 0; k < n_rules; k++) begin
        add_rule((k == 0) ? 8'h00 : states[$urandom_range(0, n_states - 1)],
                 syms[$urandom_range(0, n_syms - 1)],
                 states[$urandom_range(0, n_states - 1)]);
      end
      n_steps = $urandom_range(4, 40);
      for (k = 0; k < n_steps; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 84) begin
          feed(syms[$urandom_range(0, n_syms - 1)]);
        end else if (pick < 90) begin
          feed(rb());
        end else if (pick < 97) begin
          ctl(ACT_RESTART);
        end else if (pick < 99) begin
          add_rule(rb(), rb(), rb());
        end else begin
          ctl(ACT_CLEAR);
        end
      end
      if (prog % 8 == 5) begin
        drain();
      end
      prog++;
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("table_driven_fsm_engine_top test passed");
    end else begin
      $display("table_driven_fsm_engine_top test failed");
    end
    $finish;
  end

endmodule
